// ----- src/frequency_meter_with_lcd_readout_defines.svh -----
// ----------------------------------------------------------------------------
// Frequency meter assertion macros
// Property macros for the frequency meter, switched off by ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_METER_WITH_LCD_READOUT_DEFINES_SVH
`define FREQUENCY_METER_WITH_LCD_READOUT_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define FMR_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);
// next-cycle implication
`define FMR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);
`else
`define FMR_ASSERT_NOW(lbl, pre, post, msg)
`define FMR_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ----- src/fmr_pkg.sv -----
// ----------------------------------------------------------------------------
// Frequency meter package
// Beat types, command codes, display characters and word layout.
// ----------------------------------------------------------------------------
package fmr_pkg;

  // input and output beats
  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] adc_value;
  } in_beat_t;

  typedef struct packed {
    logic        register_select;
    logic [7:0]  lcd_byte;
    logic        last_of_run;
    logic [11:0] dac_level;
  } out_beat_t;

  // opcodes, also used as queued command kinds
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_EDGE = 2'd1;
  localparam logic [1:0] OP_ADC  = 2'd2;

  // queued command
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] adc;
  } cmd_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic [7:0]  TPU_RESET = 8'd48;
  localparam logic [13:0] FREQ_MAX  = 14'd9999;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

  // display bytes
  localparam logic [7:0] LCD_LINE1  = 8'h80;
  localparam logic [7:0] LCD_LINE2  = 8'hC0;
  localparam logic [7:0] CH_F       = 8'h46;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_H       = 8'h48;
  localparam logic [7:0] CH_Z       = 8'h7A;
  localparam logic [7:0] CH_R       = 8'h52;
  localparam logic [7:0] CH_O       = 8'h4F;
  localparam logic [7:0] CH_LOWER_H = 8'h68;
  localparam logic [7:0] CH_ZERO    = 8'h30;

  // word positions within one refresh
  localparam logic [4:0] W_LINE1_END = 5'd8;
  localparam logic [4:0] W_LAST      = 5'd17;

  typedef struct packed {
    logic       rs;
    logic [7:0] chr;
    logic       digit;
    logic [1:0] scale_idx;
  } lcd_word_t;

  // fixed part of each refresh word
  function automatic lcd_word_t lcd_word(input logic [4:0] idx);
    lcd_word_t w;
    w = '{rs: 1'b1, chr: CH_ZERO, digit: 1'b0, scale_idx: 2'd0};
    unique case (idx)
      5'd0:  begin w.rs = 1'b0; w.chr = LCD_LINE1; end
      5'd1:  w.chr = CH_F;
      5'd2:  w.chr = CH_COLON;
      5'd3:  begin w.digit = 1'b1; w.scale_idx = 2'd0; end
      5'd4:  begin w.digit = 1'b1; w.scale_idx = 2'd1; end
      5'd5:  begin w.digit = 1'b1; w.scale_idx = 2'd2; end
      5'd6:  begin w.digit = 1'b1; w.scale_idx = 2'd3; end
      5'd7:  w.chr = CH_H;
      5'd8:  w.chr = CH_Z;
      5'd9:  begin w.rs = 1'b0; w.chr = LCD_LINE2; end
      5'd10: w.chr = CH_R;
      5'd11: w.chr = CH_COLON;
      5'd12: begin w.digit = 1'b1; w.scale_idx = 2'd0; end
      5'd13: begin w.digit = 1'b1; w.scale_idx = 2'd1; end
      5'd14: begin w.digit = 1'b1; w.scale_idx = 2'd2; end
      5'd15: begin w.digit = 1'b1; w.scale_idx = 2'd3; end
      5'd16: w.chr = CH_O;
      5'd17: w.chr = CH_LOWER_H;
      default: w.chr = CH_ZERO;
    endcase
    return w;
  endfunction

  // decimal weight of a digit position, most significant first
  function automatic logic [13:0] dec_scale(input logic [1:0] i);
    logic [13:0] s;
    unique case (i)
      2'd0: s = 14'd1000;
      2'd1: s = 14'd100;
      2'd2: s = 14'd10;
      2'd3: s = 14'd1;
      default: s = 14'd1;
    endcase
    return s;
  endfunction

endpackage

// ----- src/frequency_meter_with_lcd_readout.sv -----
// A tick or first edge passes the front-end staging register and the queue before the
// back end applies it; an ADC beat starts the display refresh, one word a cycle while
// the receiver does not stall. A closing edge runs a period divide, then a frequency
// divide for a nonzero period. Commands wait in the queue during a refresh or divide.
// Synchronous reset clears control state and loads ticks_per_microsecond with 48.
// ----------------------------------------------------------------------------
// Frequency meter with display readout
// Reciprocal frequency counter: front end, command queue, back end, divider.
// ----------------------------------------------------------------------------
`include "frequency_meter_with_lcd_readout_defines.svh"

module frequency_meter_with_lcd_readout import fmr_pkg::*; #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  // divider wide enough for the count and for one million
  localparam int DW = (COUNTER_WIDTH > 20) ? COUNTER_WIDTH : 20;

  logic          q_push;
  cmd_t          q_push_cmd;
  logic          q_pop;
  cmd_t          q_pop_cmd;
  q_stat_t       q_stat;
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [DW-1:0] div_divisor;
  logic          div_done;
  logic [DW-1:0] div_quot;

  fmr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .q_stat   (q_stat)
  );

  fmr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .q_stat   (q_stat)
  );

  fmr_div #(
    .W (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  fmr_back #(
    .CW (COUNTER_WIDTH),
    .DW (DW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .q_stat       (q_stat),
    .pop          (q_pop),
    .pop_cmd      (q_pop_cmd),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quot     (div_quot)
  );

  // checks
  `FMR_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full, "push into full queue")
  `FMR_ASSERT_NOW(a_no_pop_empty, q_pop, q_stat.not_empty, "pop from empty queue")
  `FMR_ASSERT_NEXT(a_push_fills, q_push && !q_pop, q_stat.not_empty, "pushed command lost")
  `FMR_ASSERT_NOW(a_last_word, out_valid && out_data.last_of_run, out_data.lcd_byte == CH_LOWER_H, "bad last word")
  `FMR_ASSERT_NOW(a_cmd_word, out_valid && !out_data.register_select, out_data.lcd_byte == LCD_LINE1 || out_data.lcd_byte == LCD_LINE2, "bad command word")

endmodule

// ----- src/fmr_front.sv -----
// ----------------------------------------------------------------------------
// Frequency meter front end
// Takes input beats, drops unused opcodes and stages commands for the queue.
// ----------------------------------------------------------------------------
module fmr_front import fmr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_data,
  output logic     push,
  output cmd_t     push_cmd,
  input  q_stat_t  q_stat
);

  logic hold_valid;
  cmd_t hold_cmd;
  logic accept;
  logic is_cmd;

  // one staging register in front of the queue
  assign push     = hold_valid && !q_stat.full;
  assign in_stall = hold_valid && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push_cmd = hold_cmd;

  // opcode 3 carries no command
  assign is_cmd = (in_data.opcode == OP_TICK) || (in_data.opcode == OP_EDGE) ||
                  (in_data.opcode == OP_ADC);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= is_cmd;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  // command payload, sample only kept for ADC beats
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cmd.kind <= in_data.opcode;
      hold_cmd.adc  <= (in_data.opcode == OP_ADC) ? in_data.adc_value : 12'd0;
    end
  end

endmodule

// ----- src/fmr_queue.sv -----
// ----------------------------------------------------------------------------
// Frequency meter command queue
// Short FIFO that decouples the front end from the executing back end.
// ----------------------------------------------------------------------------
module fmr_queue import fmr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    pop_cmd,
  output q_stat_t q_stat
);

  cmd_t            ent [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign q_stat.full      = (count == (Q_AW+1)'(Q_DEPTH));
  assign q_stat.not_empty = (count != '0);
  assign pop_cmd          = ent[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) ent[wr_ptr] <= push_cmd;
  end

endmodule

// ----- src/fmr_div.sv -----
// ----------------------------------------------------------------------------
// Frequency meter divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fmr_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [W:0]       rem_sh;
  logic [W:0]       diff;

  // trial subtract
  assign rem_sh   = {rem, quo[W-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = quo;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[W-2:0], !diff[W]};
      rem <= diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
    end
  end

endmodule

// ----- src/fmr_back.sv -----
// ----------------------------------------------------------------------------
// Frequency meter back end
// Runs queued commands: tick counting, period and frequency divides, and the
// eighteen-word display refresh through a registered output beat.
// ----------------------------------------------------------------------------
module fmr_back import fmr_pkg::*; #(
  parameter int CW = 32,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  q_stat_t       q_stat,
  output logic          pop,
  input  cmd_t          pop_cmd,
  output logic          out_valid,
  input  logic          out_stall,
  output out_beat_t     out_data,
  output logic          div_start,
  output logic [DW-1:0] div_dividend,
  output logic [DW-1:0] div_divisor,
  input  logic          div_done,
  input  logic [DW-1:0] div_quot
);

  localparam logic [1:0] ST_IDLE       = 2'd0;
  localparam logic [1:0] ST_DIV_PERIOD = 2'd1;
  localparam logic [1:0] ST_DIV_FREQ   = 2'd2;
  localparam logic [1:0] ST_EMIT       = 2'd3;

  logic [1:0]    state;
  logic [7:0]    tpu;
  logic          edge_seen;
  logic          counting;
  logic [CW-1:0] tick_count;
  logic [13:0]   freq;
  logic [11:0]   adc_reg;
  logic [13:0]   rest;
  logic [4:0]    wi;

  logic          out_load;
  logic          period_start;
  logic          freq_start;
  lcd_word_t     word;
  logic [13:0]   scale;
  logic [13:0]   thr;
  logic [3:0]    digit;
  logic [13:0]   sub;
  logic [14:0]   sum5;
  logic [13:0]   resist;
  logic [DW-1:0] q_minus1;
  logic [13:0]   freq_calc;
  logic [CW-1:0] count_m1;

  assign pop      = (state == ST_IDLE) && q_stat.not_empty;
  assign out_load = !out_valid || !out_stall;

  // count - 1 wraps at the counter width
  assign count_m1 = tick_count - CW'(1);

  // divider requests: period first, then the reciprocal
  assign period_start = pop && (pop_cmd.kind == OP_EDGE) && edge_seen;
  assign freq_start   = (state == ST_DIV_PERIOD) && div_done && (div_quot != '0);
  assign div_start    = period_start || freq_start;

  always_comb begin
    if (period_start) begin
      div_dividend = DW'(count_m1);
      div_divisor  = (tpu == 8'd0) ? DW'(1) : DW'(tpu);
    end else begin
      div_dividend = DW'(USEC_PER_SEC);
      div_divisor  = div_quot;
    end
  end

  // frequency = quotient - 1, clamped to the display range
  assign q_minus1 = div_quot - DW'(1);
  always_comb begin
    if (div_quot == '0) begin
      freq_calc = 14'd0;
    end else if (q_minus1 > DW'(FREQ_MAX)) begin
      freq_calc = FREQ_MAX;
    end else begin
      freq_calc = q_minus1[13:0];
    end
  end

  // one decimal digit per word
  assign word  = lcd_word(wi);
  assign scale = dec_scale(word.scale_idx);
  always_comb begin
    digit = 4'd0;
    sub   = 14'd0;
    thr   = 14'd0;
    for (int k = 1; k <= 9; k++) begin
      thr = 14'(k) * scale;
      if (rest >= thr) begin
        digit = 4'(k);
        sub   = thr;
      end
    end
  end

  // adc * 5 / 4
  assign sum5   = {3'b000, adc_reg} + {1'b0, adc_reg, 2'b00};
  assign resist = {1'b0, sum5[14:2]};

  // control and measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tpu        <= TPU_RESET;
      edge_seen  <= 1'b0;
      counting   <= 1'b0;
      tick_count <= '0;
      freq       <= '0;
      wi         <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) tpu <= cfg_wr_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            unique case (pop_cmd.kind)
              OP_TICK: begin
                if (counting) tick_count <= tick_count + CW'(1);
              end
              OP_EDGE: begin
                if (!edge_seen) begin
                  tick_count <= '0;
                  counting   <= 1'b1;
                  edge_seen  <= 1'b1;
                end else begin
                  counting  <= 1'b0;
                  edge_seen <= 1'b0;
                  state     <= ST_DIV_PERIOD;
                end
              end
              OP_ADC: begin
                wi    <= '0;
                state <= ST_EMIT;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_DIV_PERIOD: begin
          if (div_done) begin
            if (div_quot == '0) begin
              freq  <= FREQ_MAX;
              state <= ST_IDLE;
            end else begin
              state <= ST_DIV_FREQ;
            end
          end
        end
        ST_DIV_FREQ: begin
          if (div_done) begin
            freq  <= freq_calc;
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            if (wi == W_LAST) begin
              state <= ST_IDLE;
            end else begin
              wi <= wi + 5'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // refresh datapath
  always_ff @(posedge clk) begin
    if (pop && (pop_cmd.kind == OP_ADC)) begin
      adc_reg <= pop_cmd.adc;
      rest    <= freq;
    end else if ((state == ST_EMIT) && out_load) begin
      if (wi == W_LINE1_END) begin
        rest <= resist;
      end else if (word.digit) begin
        rest <= rest - sub;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_load) begin
      out_data.register_select <= word.rs;
      out_data.lcd_byte        <= word.digit ? (CH_ZERO + {4'd0, digit}) : word.chr;
      out_data.last_of_run     <= (wi == W_LAST);
      out_data.dac_level       <= adc_reg;
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequency meter testbench
// Sends ticks, edge pairs and ADC samples through the input channel. Every
// accepted beat goes into a scoreboard that keeps its own copy of the counter
// and the held frequency and predicts the 18-word display refresh. Each phase
// uses a different divisor; the first and last phases have no sender gaps or
// receiver stalls, the others each a different mix of them.
// ----------------------------------------------------------------------------
module tb;
  import fmr_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         SETTLE_CYCLES  = 100;   // covers the divider after the closing edge of a pair
  localparam int         WATCHDOG_LIMIT = 5000;

  // Predicts the display words from accepted beats and checks them in order
  class meter_scoreboard;
    logic [7:0]  tpu;
    logic        armed;
    logic        running;
    logic [31:0] ticks_run;
    logic [13:0] freq_hz;
    out_beat_t   words_due[$];
    int          errors;

    function new();
      tpu       = TPU_RESET;
      armed     = 1'b0;
      running   = 1'b0;
      ticks_run = '0;
      freq_hz   = '0;
      errors    = 0;
    endfunction

    function void set_tpu(logic [7:0] v);
      tpu = v;
    endfunction

    function void push_word(logic rs, logic [7:0] chr, logic last, logic [11:0] dac);
      out_beat_t w;
      w.register_select = rs;
      w.lcd_byte        = chr;
      w.last_of_run     = last;
      w.dac_level       = dac;
      words_due.push_back(w);
    endfunction

    // four decimal digits, most significant first
    function void push_digits(logic [13:0] v, logic [11:0] dac);
      int scale;
      scale = 1000;
      for (int i = 0; i < 4; i++) begin
        push_word(1'b1, CH_ZERO + 8'((v / scale) % 10), 1'b0, dac);
        scale = scale / 10;
      end
    endfunction

    // period in us from the count, then Hz, clamped to four digits
    function logic [13:0] frequency_from_count();
      logic [31:0] div;
      logic [31:0] period;
      logic [31:0] q;
      div    = (tpu == 8'd0) ? 32'd1 : {24'd0, tpu};
      period = (ticks_run - 32'd1) / div;
      if (period == 32'd0) return FREQ_MAX;
      q = 32'(USEC_PER_SEC) / period;
      if (q == 32'd0) return 14'd0;
      if (q - 32'd1 > {18'd0, FREQ_MAX}) return FREQ_MAX;
      return 14'(q - 32'd1);
    endfunction

    function void note_beat(in_beat_t b);
      logic [13:0] ohms;
      case (b.opcode)
        OP_TICK: begin
          if (running) ticks_run = ticks_run + 32'd1;
        end
        OP_EDGE: begin
          if (!armed) begin
            ticks_run = '0;
            running   = 1'b1;
            armed     = 1'b1;
          end else begin
            freq_hz = frequency_from_count();
            running = 1'b0;
            armed   = 1'b0;
          end
        end
        OP_ADC: begin
          ohms = 14'((32'(b.adc_value) * 5) / 4);
          push_word(1'b0, LCD_LINE1, 1'b0, b.adc_value);
          push_word(1'b1, CH_F, 1'b0, b.adc_value);
          push_word(1'b1, CH_COLON, 1'b0, b.adc_value);
          push_digits(freq_hz, b.adc_value);
          push_word(1'b1, CH_H, 1'b0, b.adc_value);
          push_word(1'b1, CH_Z, 1'b0, b.adc_value);
          push_word(1'b0, LCD_LINE2, 1'b0, b.adc_value);
          push_word(1'b1, CH_R, 1'b0, b.adc_value);
          push_word(1'b1, CH_COLON, 1'b0, b.adc_value);
          push_digits(ohms, b.adc_value);
          push_word(1'b1, CH_O, 1'b0, b.adc_value);
          push_word(1'b1, CH_LOWER_H, 1'b1, b.adc_value);
        end
        default: ;  // unused opcode is dropped
      endcase
    endfunction

    function void check_word(out_beat_t got);
      out_beat_t want;
      if (words_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected display word rs=%0d byte=%h last=%0d dac=%h", $time,
                 got.register_select, got.lcd_byte, got.last_of_run, got.dac_level);
        return;
      end
      want = words_due.pop_front();
      if (got.register_select !== want.register_select || got.lcd_byte !== want.lcd_byte ||
          got.last_of_run !== want.last_of_run || got.dac_level !== want.dac_level) begin
        errors++;
        $display("%0t: display word mismatch: expected rs=%0d byte=%h last=%0d dac=%h",
                 $time, want.register_select, want.lcd_byte, want.last_of_run,
                 want.dac_level);
        $display("%0t:                           got rs=%0d byte=%h last=%0d dac=%h",
                 $time, got.register_select, got.lcd_byte, got.last_of_run,
                 got.dac_level);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  in_beat_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_beat_t  out_data;

  meter_scoreboard sb = new();
  int send_idle_pct;
  int stall_pct;
  int beats_counted;
  int idle_cycles;

  frequency_meter_with_lcd_readout dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_word(out_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
        $display("[frequency_meter_with_lcd_readout] ERROR");
        $finish;
      end
    end
  end

  // one input beat, held until taken
  task automatic send_op(input logic [1:0] op, input logic [11:0] adc);
    in_beat_t b;
    b.opcode    = op;
    b.adc_value = adc;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    in_data  = b;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(b);
    beats_counted++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic tick_run(input int n);
    for (int i = 0; i < n; i++) send_op(OP_TICK, 12'($urandom_range(4095)));
  endtask

  // full edge pair around n ticks
  task automatic measure(input int n);
    send_op(OP_EDGE, 12'($urandom_range(4095)));
    tick_run(n);
    send_op(OP_EDGE, 12'($urandom_range(4095)));
  endtask

  // hold the sender until the display queue is empty and the divider is done
  task automatic settle();
    while (sb.words_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_tpu(input logic [7:0] v);
    settle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_tpu(v);
  endtask

  function automatic logic [11:0] pick_adc();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 12'd0;
    if (r == 1) return 12'hFFF;
    return 12'($urandom_range(4095));
  endfunction

  // mostly short counts, a few in the readable range for small divisors
  function automatic int pick_ticks();
    int r;
    r = $urandom_range(99);
    if (r < 90) return $urandom_range(12);
    return $urandom_range(100, 130);
  endfunction

  task automatic run_random(input int budget);
    int start;
    int r;
    start = beats_counted;
    while (beats_counted - start < budget) begin
      r = $urandom_range(99);
      if (r < 65) begin
        measure(pick_ticks());
        repeat ($urandom_range(1, 2)) send_op(OP_ADC, pick_adc());
      end else if (r < 75) begin
        send_op(OP_EDGE, 12'($urandom_range(4095)));
      end else if (r < 85) begin
        send_op(OP_UNUSED, 12'($urandom_range(4095)));
      end else if (r < 92) begin
        tick_run($urandom_range(1, 5));
      end else begin
        send_op(OP_ADC, pick_adc());
      end
      if ($urandom_range(19) == 0) settle();
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    beats_counted = 0;
    idle_cycles   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset readout, field extremes, dropped beats
    send_op(OP_ADC, 12'd0);
    send_op(OP_ADC, 12'hFFF);
    send_op(OP_UNUSED, 12'hFFF);
    send_op(OP_TICK, 12'h000);
    send_op(OP_ADC, 12'h5A5);
    // zero count wraps to a huge period, so 0 Hz
    measure(0);
    send_op(OP_ADC, 12'hAAA);
    // one tick gives a zero period, so full scale
    measure(1);
    send_op(OP_ADC, 12'h555);

    write_tpu(8'd1);
    measure(3);
    send_op(OP_ADC, 12'h800);
    send_op(OP_UNUSED, 12'h7FF);
    send_op(OP_ADC, 12'h7FF);

    // zero divisor acts as one: 101 us period reads 9899 Hz
    write_tpu(8'd0);
    measure(102);
    send_op(OP_ADC, 12'h123);

    write_tpu(8'd255);
    measure(8);
    send_op(OP_ADC, 12'hFFE);

    // random phases, one divisor and one traffic mix each
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_tpu(TPU_RESET);
        1: write_tpu(8'd1);
        2: write_tpu(8'd255);
        3: write_tpu(8'd0);
        default: write_tpu(8'($urandom_range(2, 12)));
      endcase
      send_idle_pct = (ph == 1) ? 57 : (ph == 3) ? 13 : 0;
      stall_pct     = (ph == 2) ? 57 : (ph == 3) ? 13 : 0;
      run_random(25);
    end

    settle();
    if (sb.errors == 0 && sb.words_due.size() == 0) begin
      $display("[frequency_meter_with_lcd_readout] OK");
    end else begin
      $display("[frequency_meter_with_lcd_readout] ERROR");
    end
    $finish;
  end

endmodule
